[rtl/rtbs_pkg.sv]
package rtbs_pkg;

    localparam int VALUE_W       = 32;
    localparam int RANK_W        = 6;
    localparam int POS_W         = 6;
    localparam int MAX_ITEMS_DEF = 64;
    localparam int FIFO_DEPTH    = 4;   // power of two
    localparam int GRP_W         = 8;   // compare bits summed per group in the count tree
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 16;

    // one request handed from the front to the back
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      store;   // value goes into a cell
        logic                      last;    // closes the list
    } req_t;

endpackage

[rtl/rtbs_fifo.sv]
module rtbs_fifo import rtbs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  req_t push_data,
    output logic full,
    input  logic pop,
    output req_t pop_data,
    output logic not_empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    req_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W:0]   wr_reg, wr_next;
    logic [PTR_W:0]   rd_reg, rd_next;

    assign full      = (wr_reg[PTR_W] != rd_reg[PTR_W]) &&
                       (wr_reg[PTR_W-1:0] == rd_reg[PTR_W-1:0]);
    assign not_empty = (wr_reg != rd_reg);
    assign pop_data  = mem_reg[rd_reg[PTR_W-1:0]];

    assign wr_next = push ? wr_reg + (PTR_W+1)'(1) : wr_reg;
    assign rd_next = pop  ? rd_reg + (PTR_W+1)'(1) : rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
        end else begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg[PTR_W-1:0]] <= push_data;
        end
    end

endmodule

[rtl/rtbs_front.sv]
module rtbs_front import rtbs_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
    input  logic                 s_tlast,   // last_item
    input  logic                 fifo_full,
    output logic                 push,
    output req_t                 push_data
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic [CNT_W-1:0] list_cnt_reg, list_cnt_next;
    logic             accept;
    logic             store;

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && !fifo_full;
    // values beyond a full list are dropped; their tlast still closes it
    assign store    = (list_cnt_reg < CNT_W'(MAX_ITEMS));
    assign push     = accept && (store || s_tlast);

    assign push_data.value = $signed(s_tdata[VALUE_W-1:0]);
    assign push_data.store = store;
    assign push_data.last  = s_tlast;

    always_comb begin
        list_cnt_next = list_cnt_reg;
        if (accept) begin
            if (s_tlast) begin
                list_cnt_next = '0;
            end else if (store) begin
                list_cnt_next = list_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_cnt_reg <= '0;
        end else begin
            list_cnt_reg <= list_cnt_next;
        end
    end

endmodule

[rtl/rtbs_back.sv]
module rtbs_back import rtbs_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fifo_valid,
    output logic                 fifo_pop,
    input  req_t                 req,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [5:0] rank, [11:6] position, [15:12] zero
    output logic                 m_tlast    // last_rank
);

    localparam int SLOT_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int NGRP   = (MAX_ITEMS + GRP_W - 1) / GRP_W;
    localparam int CMP_W  = NGRP * GRP_W;
    localparam int PART_W = $clog2(GRP_W + 1);
    localparam int SUM_W  = $clog2(CMP_W + 1);

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_EMIT  = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    // cells
    logic signed [VALUE_W-1:0] value_reg [MAX_ITEMS];
    logic [RANK_W-1:0]         count_reg [MAX_ITEMS];
    logic [RANK_W-1:0]         count_next [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]      valid_reg, valid_next;
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [SLOT_W-1:0]         fill_slot;

    // count tree
    logic [CMP_W-1:0]          lt_vec;
    logic [MAX_ITEMS-1:0]      gt_vec;
    logic [CMP_W-1:0]          cmp_reg;
    logic [SLOT_W-1:0]         cmp_slot_reg;
    logic                      cmp_valid_reg;
    logic [PART_W-1:0]         part_next [NGRP];
    logic [PART_W-1:0]         part_reg  [NGRP];
    logic [SLOT_W-1:0]         part_slot_reg;
    logic                      part_valid_reg;
    logic [SUM_W-1:0]          pop_sum;
    logic [RANK_W-1:0]         pop_add;

    // emission
    logic [CNT_W-1:0]          emit_pos_reg, emit_pos_next;
    logic                      emit_fire;
    logic                      emit_last;
    logic                      out_valid_reg;
    logic [RANK_W-1:0]         out_rank_reg;
    logic [POS_W-1:0]          out_pos_reg;
    logic                      out_last_reg;

    logic                      take;
    logic                      do_load;

    assign take      = (state_reg == ST_LOAD) && fifo_valid;
    assign fifo_pop  = take;
    assign do_load   = take && req.store;
    assign fill_slot = fill_reg[SLOT_W-1:0];

    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);
    assign emit_last = ((emit_pos_reg + CNT_W'(1)) == fill_reg);

    // compare the new value against every stored cell
    always_comb begin
        lt_vec = '0;
        gt_vec = '0;
        for (int k = 0; k < MAX_ITEMS; k++) begin
            lt_vec[k] = valid_reg[k] && (value_reg[k] < req.value);
            gt_vec[k] = valid_reg[k] && (value_reg[k] > req.value);
        end
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            part_next[g] = '0;
            for (int b = 0; b < GRP_W; b++) begin
                part_next[g] = part_next[g] + PART_W'(cmp_reg[g*GRP_W + b]);
            end
        end
    end

    always_comb begin
        pop_sum = '0;
        for (int g = 0; g < NGRP; g++) begin
            pop_sum = pop_sum + SUM_W'(part_reg[g]);
        end
    end

    assign pop_add = RANK_W'(pop_sum);

    // cell counts: shift towards cell 0 while emitting, else accumulate
    always_comb begin
        for (int k = 0; k < MAX_ITEMS; k++) begin
            count_next[k] = count_reg[k];
        end
        if (emit_fire) begin
            for (int k = 0; k < MAX_ITEMS - 1; k++) begin
                count_next[k] = count_reg[k+1];
            end
        end else begin
            for (int k = 0; k < MAX_ITEMS; k++) begin
                if (do_load && (fill_slot == SLOT_W'(k))) begin
                    count_next[k] = '0;
                end else begin
                    count_next[k] = count_reg[k] + RANK_W'(gt_vec[k] && do_load) +
                                    ((part_valid_reg && (part_slot_reg == SLOT_W'(k))) ?
                                     pop_add : RANK_W'(0));
                end
            end
        end
    end

    always_comb begin
        valid_next    = valid_reg;
        fill_next     = fill_reg;
        emit_pos_next = emit_pos_reg;
        state_next    = state_reg;
        if (do_load) begin
            valid_next[fill_slot] = 1'b1;
            fill_next             = fill_reg + CNT_W'(1);
        end
        unique case (state_reg)
            ST_LOAD: begin
                if (take && req.last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!cmp_valid_reg && !part_valid_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    emit_pos_next = emit_pos_reg + CNT_W'(1);
                    if (emit_last) begin
                        emit_pos_next = '0;
                        valid_next    = '0;
                        fill_next     = '0;
                        state_next    = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            valid_reg      <= '0;
            fill_reg       <= '0;
            emit_pos_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            part_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            fill_reg       <= fill_next;
            emit_pos_reg   <= emit_pos_next;
            cmp_valid_reg  <= do_load;
            part_valid_reg <= cmp_valid_reg;
            if (emit_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_ITEMS; k++) begin
            count_reg[k] <= count_next[k];
            if (do_load && (fill_slot == SLOT_W'(k))) begin
                value_reg[k] <= req.value;
            end
        end
        cmp_reg       <= lt_vec;
        cmp_slot_reg  <= fill_slot;
        part_reg      <= part_next;
        part_slot_reg <= cmp_slot_reg;
        if (emit_fire) begin
            out_rank_reg <= count_reg[0];
            out_pos_reg  <= POS_W'(emit_pos_reg);
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RANK_W - POS_W){1'b0}}, out_pos_reg, out_rank_reg};
    assign m_tlast  = out_last_reg;

    a_emit_after_tree: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (!cmp_valid_reg && !part_valid_reg))
        else $error("emission started with counts still in the tree");

    a_valid_matches_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(fill_reg))
        else $error("cell valid bits disagree with fill count");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(MAX_ITEMS))
        else $error("fill count beyond cell row");

    a_store_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        do_load |-> (fill_reg < CNT_W'(MAX_ITEMS)))
        else $error("front and back disagree on list length");

    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && emit_last) |=> ((state_reg == ST_LOAD) && (fill_reg == '0)))
        else $error("list not cleared after final rank");

endmodule

[rtl/rank_transform_by_sort.sv]
// Rank transform of a list of signed 32-bit values.
//
// Input: one value per request on s_tdata[31:0]; s_tlast closes the list.
// Values beyond MAX_ITEMS in one list are dropped, but their s_tlast still
// closes the list. Output: one request per stored value, in input order,
// with the count of stored values strictly below it (rank, m_tdata[5:0]),
// its input position (m_tdata[11:6]); m_tlast flags the final one.
//
// Loading takes one value per cycle while the queue holds one: each value
// is compared against the whole cell row at once; the count of smaller
// cells goes through a two-stage registered adder tree (compare register,
// then group-sum register) and lands in the new cell. After the closing
// request the back waits for that tree to empty, then shifts one rank per
// cycle out of cell 0 into the output register. While ranks go out the
// front keeps taking requests into a four-entry queue; once it fills,
// s_tready drops. A stalled receiver holds the output register and halts
// the shift. Synchronous reset (aresetn low) empties the queue, the cell
// row and the output register.
module rank_transform_by_sort import rtbs_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
    input  logic                 s_tlast,   // last_item
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [5:0] rank, [11:6] position, [15:12] zero
    output logic                 m_tlast    // last_rank
);

    logic push;
    req_t push_data;
    logic fifo_full;
    logic fifo_pop;
    req_t pop_data;
    logic fifo_valid;

    // front: takes requests, marks dropped and closing ones
    rtbs_front #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .fifo_full (fifo_full),
        .push      (push),
        .push_data (push_data)
    );

    // short queue decoupling front and back
    rtbs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .pop_data  (pop_data),
        .not_empty (fifo_valid)
    );

    // back: cell row, count tree and rank emission
    rtbs_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_valid (fifo_valid),
        .fifo_pop   (fifo_pop),
        .req        (pop_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

[test/tb_rank_transform_by_sort.sv]
// Self-checking bench for rank_transform_by_sort.
//
// A queue of pending requests is built at time zero: a few hand-picked lists
// (single value, corner values, ties, a descending run), then random lists of
// random length. An overfull list and occasional long random lists push past
// MAX_ITEMS to exercise the drop-on-full path. A clocked driver feeds the
// queue into the slave side, a clocked monitor takes the master side, and
// both insert random idle bursts until the tail of the run. Each accepted
// closing request makes the bench work out the rank of every stored value
// and queue the ranks due; the monitor checks each rank taken against the oldest.
module tb_rank_transform_by_sort;
    import rtbs_pkg::*;

    localparam int MAX_ITEMS   = MAX_ITEMS_DEF;
    localparam int RANDOM_REQS = 500;
    localparam int CALM_TAIL   = 80;      // last requests sent without idling
    localparam int QUIET_LIMIT = 2000;    // cycles with no handshake at all
    localparam int DRAIN_WAIT  = 2 * MAX_ITEMS + 16;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    // how list values are spread
    typedef enum int {
        SPREAD_FULL,     // any 32-bit pattern
        SPREAD_NARROW,   // a handful of small values, lots of ties
        SPREAD_CORNER,   // around the signed extremes and zero
        SPREAD_MIXED     // any of the above, per value
    } spread_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } list_req_t;

    typedef struct {
        logic [RANK_W-1:0] rank;
        logic [POS_W-1:0]  position;
        logic              last_rank;
    } rank_req_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    list_req_t pending[$];          // requests still to be sent
    list_req_t next_req;
    logic signed [VALUE_W-1:0] open_list[$];   // values of the list being loaded
    rank_req_t ranks_due[$];        // ranks owed by the block, oldest first

    int  fails = 0;
    int  quiet = 0;
    logic calm_phase = 1'b0;        // tail of the run: no idling on either side

    int  src_gap = 0;
    int  src_pct = 0;
    int  src_tick = 0;
    int  snk_gap = 0;
    int  snk_pct = 0;
    int  snk_tick = 0;

    rank_transform_by_sort #(
        .MAX_ITEMS (MAX_ITEMS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // [31:0] value
        .s_tlast  (s_tlast),     // last_item
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // [5:0] rank, [11:6] position, [15:12] zero
        .m_tlast  (m_tlast)      // last_rank
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Rank prediction
    // ------------------------------------------------------------------

    // Take one accepted request into the open list; on the closing one,
    // every stored value is owed a rank: the count of stored values below it.
    // Values past MAX_ITEMS are dropped but their last flag still counts.
    task automatic take_list_req(input logic signed [VALUE_W-1:0] value,
                                 input logic last);
        rank_req_t r;
        int below;
        if (open_list.size() < MAX_ITEMS)
            open_list.push_back(value);
        if (last) begin
            for (int k = 0; k < open_list.size(); k++) begin
                below = 0;
                foreach (open_list[j])
                    if (open_list[j] < open_list[k])
                        below++;
                r.rank      = below[RANK_W-1:0];
                r.position  = k[POS_W-1:0];
                r.last_rank = (k == open_list.size() - 1);
                ranks_due.push_back(r);
            end
            open_list.delete();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        fails++;
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_rank_req(input logic [M_TDATA_W-1:0] data, input logic last);
        rank_req_t want;
        if (ranks_due.size() == 0) begin
            report_mismatch("rank request with none due, position", int'(data[11:6]), -1);
        end else begin
            want = ranks_due.pop_front();
            if (data[5:0] !== want.rank)
                report_mismatch($sformatf("rank at position %0d", want.position),
                                int'(data[5:0]), int'(want.rank));
            if (data[11:6] !== want.position)
                report_mismatch("position", int'(data[11:6]), int'(want.position));
            if (last !== want.last_rank)
                report_mismatch($sformatf("last flag at position %0d", want.position),
                                int'(last), int'(want.last_rank));
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic logic signed [VALUE_W-1:0] pick_value(input spread_t spread);
        spread_t s;
        s = spread;
        if (s == SPREAD_MIXED)
            s = spread_t'($urandom_range(0, 2));
        case (s)
            SPREAD_NARROW: return $urandom_range(0, 9) - 5;
            SPREAD_CORNER: begin
                case ($urandom_range(0, 6))
                    0: return VALUE_MIN;
                    1: return VALUE_MIN + 1;
                    2: return VALUE_MAX;
                    3: return VALUE_MAX - 1;
                    4: return -1;
                    5: return 1;
                    default: return 0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_value(input logic signed [VALUE_W-1:0] value, input logic last);
        list_req_t r;
        r.value = value;
        r.last  = last;
        pending.push_back(r);
    endtask

    task automatic queue_list(input int len, input spread_t spread);
        for (int i = 0; i < len; i++)
            queue_value(pick_value(spread), i == len - 1);
    endtask

    initial begin
        int len;
        int target;

        // single value: rank 0, position 0, flagged last
        queue_value(32'sd5, 1'b1);
        // signed extremes, zero, ties and alternating bit patterns
        queue_value(VALUE_MAX, 1'b0);
        queue_value(VALUE_MIN, 1'b0);
        queue_value(0, 1'b0);
        queue_value(-1, 1'b0);
        queue_value(1, 1'b0);
        queue_value(VALUE_MIN, 1'b0);
        queue_value(VALUE_MAX, 1'b0);
        queue_value(32'sh5555_5555, 1'b0);
        queue_value(32'shAAAA_AAAA, 1'b1);
        // all equal: every rank is 0
        repeat (3) queue_value(-7, 1'b0);
        queue_value(-7, 1'b1);
        // descending: earlier cells must pick up counts from later ones
        queue_value(40, 1'b0);
        queue_value(30, 1'b0);
        queue_value(20, 1'b0);
        queue_value(10, 1'b0);
        queue_value(0, 1'b1);

        // random part: a full list, an overfull one, then mostly short lists
        target = pending.size() + RANDOM_REQS;
        queue_list(MAX_ITEMS, SPREAD_MIXED);
        queue_list(MAX_ITEMS + 6, SPREAD_NARROW);
        while (pending.size() < target) begin
            if ($urandom_range(0, 15) == 0)
                len = $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6);
            else
                len = $urandom_range(1, 12);
            queue_list(len, spread_t'($urandom_range(0, 3)));
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // all requests out, all ranks in, then a settling wait for strays
        while (pending.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (ranks_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: slave side. A request is held until taken; a fresh one is
    // loaded only when the slot is empty or the current one was just taken.
    // Random idle bursts; the gap rate is re-rolled on the source tick counter,
    // at times to zero, so that there are long stretches without any gaps as well.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                take_list_req(s_tdata, s_tlast);
            src_tick++;
            if (src_tick % 64 == 0)
                src_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (!calm_phase && $urandom_range(0, 99) < src_pct) begin
                    src_gap = $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end else begin
                    next_req = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_req.value;
                    s_tlast  <= next_req.last;
                end
            end
            calm_phase <= (pending.size() < CALM_TAIL);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: master side. Checks each rank request taken, then decides
    // on the ready for the next cycle with its own stall bursts.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (m_tvalid && m_tready)
                check_rank_req(m_tdata, m_tlast);
            snk_tick++;
            if (snk_tick % 64 == 32)
                snk_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
            if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 99) < snk_pct) begin
                snk_gap = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog: a hung handshake on both sides ends the run
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule
